@@ rtl/cvs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvs_pkg
// Shared types and constants of the chunked vector stack engine.
// ----------------------------------------------------------------------------
package cvs_pkg;

	localparam int IDX_W      = 8;
	localparam int REG_W      = 9;
	localparam int CFG_IDX_W  = 1;
	localparam int FREE_CHUNKS = 2;

	localparam logic [REG_W-1:0] ORIG_CAP_RST = 9'd16;
	localparam logic [REG_W-1:0] CHUNK_RST    = 9'd8;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIG_CAP = 1'b0,
		REG_CHUNK    = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_REMOVE = 2'd1,
		OP_GET    = 2'd2,
		OP_SET    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_OVERFLOW  = 3'd1,
		ST_UNDERFLOW = 3'd2,
		ST_BOUNDS    = 3'd3,
		ST_ALLOC     = 3'd4
	} status_t;

	// classified request handed from front to back
	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] index;
		logic             idx_beyond;
	} cmd_t;

endpackage
`default_nettype wire

@@ rtl/cvs_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvs_req_if / cvs_rsp_if
// Valid/ready channels for requests and results of the stack engine.
// ----------------------------------------------------------------------------
interface cvs_req_if #(
	parameter int ELEM_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic [1:0]                    op;
	logic [cvs_pkg::IDX_W-1:0]     index;
	logic [ELEM_WIDTH-1:0]         element;

	modport source (output valid, output op, output index, output element, input ready);
	modport sink (input valid, input op, input index, input element, output ready);
endinterface

interface cvs_rsp_if #(
	parameter int ELEM_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic [2:0]                    status;
	logic [ELEM_WIDTH-1:0]         element_out;
	logic [cvs_pkg::REG_W-1:0]     fill_count;
	logic [cvs_pkg::REG_W-1:0]     capacity_now;

	modport source (output valid, output status, output element_out, output fill_count,
		output capacity_now, input ready);
	modport sink (input valid, input status, input element_out, input fill_count,
		input capacity_now, output ready);
endinterface
`default_nettype wire

@@ rtl/chunked_vector_stack_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// chunked_vector_stack_engine
// Indexed stack store with chunked logical capacity accounting.
// ----------------------------------------------------------------------------
// The engine takes one request per cycle (append, remove, get, set) while
// neither side stalls and returns exactly one result for each, in order. A
// request passes through the front queue and then the registered read port
// and result register. A two-entry queue parts the request side from execution
// and a result register parts execution from the result side; a stalled result
// side holds execution, and the request side once the queue is full. The store
// is not cleared at reset; its entries are only read after they were written.
// The user must make configuration writes (original capacity at index 0, chunk
// size at index 1) only while no request is in flight; the block does not
// enforce this. Writing the original capacity empties the stack.
// ----------------------------------------------------------------------------
module chunked_vector_stack_engine #(
	parameter int DEPTH      = 256,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cvs_pkg::REG_W-1:0]     cfg_data,
	cvs_req_if.sink                            req,
	cvs_rsp_if.source                          rsp
);

	logic                  q_valid;
	logic                  q_ready;
	cvs_pkg::cmd_t         q_cmd;
	logic [ELEM_WIDTH-1:0] q_elem;

	cvs_front #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.q_cmd   (q_cmd),
		.q_elem  (q_elem)
	);

	cvs_back #(
		.DEPTH      (DEPTH),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_cmd     (q_cmd),
		.q_elem    (q_elem),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

@@ rtl/cvs_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvs_front
// Accepts requests, classifies them and buffers them in a two-entry queue.
// ----------------------------------------------------------------------------
module cvs_front #(
	parameter int DEPTH      = 256,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	cvs_req_if.sink                    req,
	output logic                       q_valid,
	input  wire logic                  q_ready,
	output cvs_pkg::cmd_t              q_cmd,
	output logic [ELEM_WIDTH-1:0]      q_elem
);

	cvs_pkg::cmd_t         cmd_q  [2];
	logic [ELEM_WIDTH-1:0] elem_q [2];
	logic                  wptr_q;
	logic                  rptr_q;
	logic [1:0]            used_q;
	cvs_pkg::cmd_t         cmd_in;
	logic                  push;
	logic                  pop;

	// index beyond the physical store is known before execution
	always_comb begin
		cmd_in.op         = cvs_pkg::op_t'(req.op);
		cmd_in.index      = req.index;
		cmd_in.idx_beyond = (32'(req.index) >= 32'(DEPTH));
	end

	assign req.ready = (used_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign q_valid   = (used_q != 2'd0);
	assign pop       = q_valid && q_ready;
	assign q_cmd     = cmd_q[rptr_q];
	assign q_elem    = elem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			used_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			priority if (push && !pop) begin
				used_q <= used_q + 2'd1;
			end else if (pop && !push) begin
				used_q <= used_q - 2'd1;
			end else begin
				used_q <= used_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wptr_q]  <= cmd_in;
			elem_q[wptr_q] <= req.element;
		end
	end

endmodule
`default_nettype wire

@@ rtl/cvs_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cvs_back
// Executes queued requests against the entry store and the capacity counters,
// and holds the result until it is taken.
// ----------------------------------------------------------------------------
module cvs_back #(
	parameter int DEPTH      = 256,
	parameter int ELEM_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [cvs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [cvs_pkg::REG_W-1:0]     cfg_data,
	input  wire logic                          q_valid,
	output logic                               q_ready,
	input  wire cvs_pkg::cmd_t                 q_cmd,
	input  wire logic [ELEM_WIDTH-1:0]         q_elem,
	cvs_rsp_if.source                          rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int KW = (CW > cvs_pkg::REG_W) ? CW : cvs_pkg::REG_W;
	localparam int SW = KW + 2;

	logic [ELEM_WIDTH-1:0]       mem [DEPTH];
	logic [ELEM_WIDTH-1:0]       rdata_q;
	logic [cvs_pkg::REG_W-1:0]   orig_q;
	logic [cvs_pkg::REG_W-1:0]   chunk_q;
	logic [CW-1:0]               count_q;
	logic [KW-1:0]               cap_q;
	logic                        out_v_q;
	cvs_pkg::status_t            status_q;
	logic                        sel_q;
	logic [cvs_pkg::REG_W-1:0]   fill_q;
	logic [cvs_pkg::REG_W-1:0]   capo_q;

	logic                        fire;
	logic [CW-1:0]               count_d;
	logic [KW-1:0]               cap_d;
	cvs_pkg::status_t            status_d;
	logic                        sel_d;
	logic                        wr_en;
	logic                        rd_en;
	logic [AW-1:0]               wr_addr;
	logic [AW-1:0]               rd_addr;
	logic [SW-1:0]               cnt_ext;
	logic [SW-1:0]               cap_ext;
	logic [SW-1:0]               chk_ext;
	logic [SW-1:0]               grown;
	logic [SW-1:0]               idx_ext;
	logic [SW-1:0]               dep_ext;
	logic [SW-1:0]               new_cnt;

	assign q_ready = !out_v_q || rsp.ready;
	assign fire    = q_valid && q_ready;

	always_comb begin
		cnt_ext  = SW'(count_q);
		cap_ext  = SW'(cap_q);
		chk_ext  = SW'(chunk_q);
		grown    = cap_ext + chk_ext;
		idx_ext  = SW'(q_cmd.index);
		dep_ext  = SW'(DEPTH);
		new_cnt  = cnt_ext - SW'(1);
		count_d  = count_q;
		cap_d    = cap_q;
		status_d = cvs_pkg::ST_OK;
		sel_d    = 1'b0;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		wr_addr  = AW'(count_q);
		rd_addr  = AW'(q_cmd.index);
		unique case (q_cmd.op)
			cvs_pkg::OP_APPEND: begin
				priority if (grown < cnt_ext + SW'(1)) begin
					status_d = cvs_pkg::ST_OVERFLOW;
				end else if (cnt_ext >= dep_ext) begin
					status_d = cvs_pkg::ST_ALLOC;
				end else if (cnt_ext == cap_ext && grown > dep_ext) begin
					status_d = cvs_pkg::ST_ALLOC;
				end else begin
					if (cnt_ext == cap_ext) cap_d = KW'(grown);
					wr_en   = 1'b1;
					count_d = CW'(cnt_ext + SW'(1));
				end
			end
			cvs_pkg::OP_REMOVE: begin
				if (count_q == '0) begin
					status_d = cvs_pkg::ST_UNDERFLOW;
				end else begin
					count_d = CW'(new_cnt);
					rd_addr = AW'(new_cnt);
					rd_en   = 1'b1;
					sel_d   = 1'b1;
					// give back one chunk when above the starting size and more than two chunks are free
					if (cap_ext > SW'(orig_q) &&
						(cap_ext - new_cnt) > (chk_ext * SW'(cvs_pkg::FREE_CHUNKS))) begin
						cap_d = KW'(cap_ext - chk_ext);
					end
				end
			end
			cvs_pkg::OP_GET, cvs_pkg::OP_SET: begin
				if (idx_ext >= cnt_ext || q_cmd.idx_beyond) begin
					status_d = cvs_pkg::ST_BOUNDS;
				end else if (q_cmd.op == cvs_pkg::OP_GET) begin
					rd_en = 1'b1;
					sel_d = 1'b1;
				end else begin
					wr_en   = 1'b1;
					wr_addr = AW'(q_cmd.index);
				end
			end
			default: begin
				status_d = cvs_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fire && wr_en) mem[wr_addr] <= q_elem;
		if (fire && rd_en) rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orig_q  <= cvs_pkg::ORIG_CAP_RST;
			chunk_q <= cvs_pkg::CHUNK_RST;
			count_q <= '0;
			cap_q   <= KW'(cvs_pkg::ORIG_CAP_RST);
			out_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cvs_pkg::cfg_reg_t'(cfg_index))
					cvs_pkg::REG_ORIG_CAP: begin
						orig_q  <= cfg_data;
						cap_q   <= KW'(cfg_data);
						count_q <= '0;
					end
					cvs_pkg::REG_CHUNK: begin
						chunk_q <= cfg_data;
					end
					default: begin
						chunk_q <= chunk_q;
					end
				endcase
			end else if (fire) begin
				count_q <= count_d;
				cap_q   <= cap_d;
			end
			if (fire) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= status_d;
			sel_q    <= sel_d;
			fill_q   <= cvs_pkg::REG_W'(count_d);
			capo_q   <= cvs_pkg::REG_W'(cap_d);
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = status_q;
	assign rsp.element_out  = sel_q ? rdata_q : '0;
	assign rsp.fill_count   = fill_q;
	assign rsp.capacity_now = capo_q;

	a_count_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(count_q) <= SW'(DEPTH))
		else $error("entry count beyond store depth");

	a_count_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(count_q) <= SW'(cap_q))
		else $error("entry count beyond logical capacity");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !cfg_we && q_cmd.op == cvs_pkg::OP_APPEND && status_d == cvs_pkg::ST_OK
		|=> count_q == $past(count_q) + CW'(1))
		else $error("successful append did not add an entry");

	a_remove_pops: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !cfg_we && q_cmd.op == cvs_pkg::OP_REMOVE && count_q != '0
		|=> count_q == $past(count_q) - CW'(1))
		else $error("successful remove did not drop an entry");

endmodule
`default_nettype wire

@@ bench/tb_chunked_vector_stack_engine.sv @@
// ----------------------------------------------------------------------------
// tb_chunked_vector_stack_engine
// Self-checking bench for the chunked vector stack engine. A scoreboard keeps
// its own copy of the stack, the entry count and the logical capacity, works
// out the result of every accepted request and compares it with the result
// that leaves the block, in order. Directed requests cover the empty stack,
// bounds, overflow and allocation errors, then random grow and drain mixes run
// under several capacity and chunk settings with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_chunked_vector_stack_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 256;
	localparam int ELEM_W      = 32;
	localparam int IDLE_LIMIT  = 3000;

	typedef struct {
		cvs_pkg::status_t           status;
		logic [ELEM_W-1:0]          element;
		logic [cvs_pkg::REG_W-1:0]  fill;
		logic [cvs_pkg::REG_W-1:0]  cap;
	} stack_result_t;

	class stack_scoreboard;
		logic [ELEM_W-1:0] entries [STORE_DEPTH];
		int                fill;
		int                cap;
		int                orig_cap;
		int                chunk;
		stack_result_t     expected_q [$];
		int unsigned       errors;
		int unsigned       checked;
		int unsigned       status_tally [5];
		int unsigned       grows;
		int unsigned       shrinks;
		int                deepest;

		function new();
			orig_cap = int'(cvs_pkg::ORIG_CAP_RST);
			chunk    = int'(cvs_pkg::CHUNK_RST);
			cap      = orig_cap;
			fill     = 0;
		endfunction

		function void write_reg(cvs_pkg::cfg_reg_t r, logic [cvs_pkg::REG_W-1:0] v);
			if (r == cvs_pkg::REG_ORIG_CAP) begin
				orig_cap = int'(v);
				cap      = int'(v);
				fill     = 0;
			end else begin
				chunk = int'(v);
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_request(cvs_pkg::op_t op, logic [cvs_pkg::IDX_W-1:0] idx,
				logic [ELEM_W-1:0] elem);
			stack_result_t r;
			r.status  = cvs_pkg::ST_OK;
			r.element = '0;
			case (op)
				cvs_pkg::OP_APPEND: begin
					if (cap + chunk < fill + 1)
						r.status = cvs_pkg::ST_OVERFLOW;
					else if (fill >= STORE_DEPTH)
						r.status = cvs_pkg::ST_ALLOC;
					else if (fill == cap && cap + chunk > STORE_DEPTH)
						r.status = cvs_pkg::ST_ALLOC;
					else begin
						if (fill == cap) begin
							cap += chunk;
							grows++;
						end
						entries[fill] = elem;
						fill++;
					end
				end
				cvs_pkg::OP_REMOVE: begin
					if (fill == 0)
						r.status = cvs_pkg::ST_UNDERFLOW;
					else begin
						fill--;
						r.element = entries[fill];
						// give back one chunk when plenty of room is left
						if (cap > orig_cap && cap - fill > chunk * cvs_pkg::FREE_CHUNKS) begin
							cap -= chunk;
							shrinks++;
						end
					end
				end
				default: begin
					if (idx >= fill)
						r.status = cvs_pkg::ST_BOUNDS;
					else if (op == cvs_pkg::OP_GET)
						r.element = entries[idx];
					else
						entries[idx] = elem;
				end
			endcase
			r.fill = fill[cvs_pkg::REG_W-1:0];
			r.cap  = cap[cvs_pkg::REG_W-1:0];
			if (fill > deepest)
				deepest = fill;
			status_tally[r.status]++;
			expected_q.push_back(r);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("[%0t] ERROR: %s", $realtime, msg);
		endfunction

		function void check_result(logic [2:0] st, logic [ELEM_W-1:0] el,
				logic [cvs_pkg::REG_W-1:0] fc, logic [cvs_pkg::REG_W-1:0] cn);
			stack_result_t want;
			if (expected_q.size() == 0) begin
				flag($sformatf("result with no request outstanding: status %0d", st));
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (st !== want.status || el !== want.element || fc !== want.fill ||
					cn !== want.cap)
				flag($sformatf({"result %0d mismatch (expected/actual): status %0d/%0d ",
					"element %h/%h fill %0d/%0d capacity %0d/%0d"}, checked,
					want.status, st, want.element, el, want.fill, fc, want.cap, cn));
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [cvs_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [cvs_pkg::REG_W-1:0]     cfg_data;

	cvs_req_if #(.ELEM_WIDTH(ELEM_W)) req_ch ();
	cvs_rsp_if #(.ELEM_WIDTH(ELEM_W)) rsp_ch ();

	chunked_vector_stack_engine #(
		.DEPTH      (STORE_DEPTH),
		.ELEM_WIDTH (ELEM_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	stack_scoreboard sb;
	int unsigned     no_gap_left;
	int unsigned     idle_cycles;
	int unsigned     phases;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: stall at random, now and then a long stretch with none or a long stall
	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			rsp_ch.ready <= 1'b1;
			if ($urandom_range(0, 99) < 8)
				repeat ($urandom_range(40, 120)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
			rsp_ch.ready <= 1'b0;
			if ($urandom_range(0, 99) < 6)
				repeat ($urandom_range(10, 30)) @(posedge clk);
			else
				repeat ($urandom_range(1, 2)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
			sb.check_result(rsp_ch.status, rsp_ch.element_out, rsp_ch.fill_count,
				rsp_ch.capacity_now);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[%0t] timeout: no handshake for %0d cycles, %0d results pending",
					$realtime, IDLE_LIMIT, sb.pending());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic int pick_gap();
		int k;
		if (no_gap_left > 0) begin
			no_gap_left--;
			return 0;
		end
		k = $urandom_range(0, 99);
		if (k < 3)
			no_gap_left = $urandom_range(20, 60);
		if (k < 40)
			return 0;
		if (k < 85)
			return $urandom_range(1, 3);
		if (k < 96)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [ELEM_W-1:0] pick_element();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return '0;
		if (k == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic send_request(cvs_pkg::op_t op, logic [cvs_pkg::IDX_W-1:0] idx,
			logic [ELEM_W-1:0] elem);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.op      <= op;
		req_ch.index   <= idx;
		req_ch.element <= elem;
		do
			@(posedge clk);
		while (req_ch.ready !== 1'b1);
		sb.note_request(op, idx, elem);
	endtask

	// registers change only with nothing in flight
	task automatic program_reg(cvs_pkg::cfg_reg_t r, logic [cvs_pkg::REG_W-1:0] v);
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= v;
		@(posedge clk);
		sb.write_reg(r, v);
		cfg_we <= 1'b0;
	endtask

	task automatic set_capacity(logic [cvs_pkg::REG_W-1:0] orig,
			logic [cvs_pkg::REG_W-1:0] chunk);
		program_reg(cvs_pkg::REG_CHUNK, chunk);
		program_reg(cvs_pkg::REG_ORIG_CAP, orig);
		phases++;
	endtask

	// mostly in-range indexes, some right at the top and some anywhere
	task automatic run_mix(int n, int app_pct, int rem_pct);
		int                        k;
		int                        f;
		cvs_pkg::op_t              op;
		logic [cvs_pkg::IDX_W-1:0] idx;
		repeat (n) begin
			k = $urandom_range(0, 99);
			if (k < app_pct)
				op = cvs_pkg::OP_APPEND;
			else if (k < app_pct + rem_pct)
				op = cvs_pkg::OP_REMOVE;
			else if (k[0])
				op = cvs_pkg::OP_GET;
			else
				op = cvs_pkg::OP_SET;
			f = sb.fill;
			k = $urandom_range(0, 9);
			if (f > 0 && k < 8)
				idx = cvs_pkg::IDX_W'($urandom_range(0, f - 1));
			else if (k == 8 && f < STORE_DEPTH)
				idx = cvs_pkg::IDX_W'(f);
			else
				idx = cvs_pkg::IDX_W'($urandom_range(0, 255));
			send_request(op, idx, pick_element());
		end
	endtask

	initial begin
		sb             = new();
		no_gap_left    = 0;
		idle_cycles    = 0;
		phases         = 0;
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = cvs_pkg::REG_ORIG_CAP;
		cfg_data       = '0;
		req_ch.valid   = 1'b0;
		req_ch.op      = cvs_pkg::OP_APPEND;
		req_ch.index   = '0;
		req_ch.element = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty stack, extremes of the element word, bounds at the top
		send_request(cvs_pkg::OP_REMOVE, 8'd0, '1);
		send_request(cvs_pkg::OP_GET, 8'd0, '0);
		send_request(cvs_pkg::OP_SET, 8'd255, '1);
		send_request(cvs_pkg::OP_APPEND, 8'd255, '0);
		send_request(cvs_pkg::OP_APPEND, 8'd0, '1);
		send_request(cvs_pkg::OP_APPEND, 8'd17, 32'h5a5a_5a5a);
		send_request(cvs_pkg::OP_GET, 8'd0, '0);
		send_request(cvs_pkg::OP_GET, 8'd1, '0);
		send_request(cvs_pkg::OP_GET, 8'd3, '0);
		send_request(cvs_pkg::OP_SET, 8'd1, 32'ha5a5_a5a5);
		send_request(cvs_pkg::OP_GET, 8'd1, '1);
		send_request(cvs_pkg::OP_GET, 8'd255, '0);
		send_request(cvs_pkg::OP_REMOVE, 8'd0, '0);
		send_request(cvs_pkg::OP_REMOVE, 8'd0, '0);
		send_request(cvs_pkg::OP_REMOVE, 8'd0, '0);
		send_request(cvs_pkg::OP_REMOVE, 8'd0, '0);

		// zero chunk: appending at full capacity overflows
		set_capacity(9'd2, 9'd0);
		send_request(cvs_pkg::OP_APPEND, 8'd0, 32'h1111_1111);
		send_request(cvs_pkg::OP_APPEND, 8'd0, 32'h2222_2222);
		send_request(cvs_pkg::OP_APPEND, 8'd0, 32'h3333_3333);
		send_request(cvs_pkg::OP_GET, 8'd1, '0);

		// chunk of the full depth: growth would pass the physical depth
		set_capacity(9'd1, 9'd256);
		send_request(cvs_pkg::OP_APPEND, 8'd0, 32'hdead_beef);
		send_request(cvs_pkg::OP_APPEND, 8'd0, 32'hcafe_f00d);

		// zero original capacity grows on the first append
		set_capacity(9'd0, 9'd1);
		send_request(cvs_pkg::OP_APPEND, 8'd0, 32'h0000_0001);
		send_request(cvs_pkg::OP_APPEND, 8'd0, 32'h8000_0000);
		send_request(cvs_pkg::OP_REMOVE, 8'd0, '0);

		set_capacity(cvs_pkg::ORIG_CAP_RST, cvs_pkg::CHUNK_RST);
		run_mix(130, 70, 10);
		run_mix(110, 10, 70);
		run_mix(160, 40, 30);

		// fill the physical store to the last entry
		set_capacity(9'd256, 9'd1);
		run_mix(380, 88, 4);

		set_capacity(9'd0, 9'd3);
		run_mix(100, 70, 10);
		run_mix(100, 10, 70);
		run_mix(100, 40, 40);

		// full at 250, next chunk would not fit
		set_capacity(9'd250, 9'd8);
		run_mix(330, 88, 4);

		set_capacity(cvs_pkg::REG_W'($urandom_range(0, 40)),
			cvs_pkg::REG_W'($urandom_range(0, 12)));
		run_mix(150, 70, 10);
		run_mix(150, 10, 70);
		run_mix(150, 40, 30);

		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("%0d results checked over %0d settings: ok %0d, overflow %0d,",
			sb.checked, phases + 1, sb.status_tally[cvs_pkg::ST_OK],
			sb.status_tally[cvs_pkg::ST_OVERFLOW]);
		$display("underflow %0d, bounds %0d, alloc %0d, deepest stack %0d,",
			sb.status_tally[cvs_pkg::ST_UNDERFLOW], sb.status_tally[cvs_pkg::ST_BOUNDS],
			sb.status_tally[cvs_pkg::ST_ALLOC], sb.deepest);
		$display("%0d grow and %0d shrink steps, %0d mismatches",
			sb.grows, sb.shrinks, sb.errors);
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
